// File: rtl/page_range_reserve_allocator_core_macros.svh
// ----------------------------------------------------------------------------
// page range reserve allocator assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef PAGE_RANGE_RESERVE_ALLOCATOR_CORE_MACROS_SVH
`define PAGE_RANGE_RESERVE_ALLOCATOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// clocked check, held off while reset is low
`define PRRA_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also runs during reset
`define PRRA_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PRRA_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define PRRA_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/prra_pkg.sv
// ----------------------------------------------------------------------------
// prra_pkg
// shared types, codes and defaults of the page range reserve allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prra_pkg;

    // default sizing
    localparam int DEF_TABLE_DEPTH = 128;
    localparam int DEF_PAGE_BYTES  = 4096;

    // action codes
    localparam logic [1:0] ACT_RESERVE = 2'd0;
    localparam logic [1:0] ACT_QUERY   = 2'd1;
    localparam logic [1:0] ACT_ALLOC   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ALLOC_START = 2'd0;
    localparam logic [1:0] CFG_ALLOC_LIMIT = 2'd1;
    localparam logic [1:0] CFG_SEALED      = 2'd2;

    // error codes
    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_BAD_RSV   = 3'd1,
        ERR_FULL      = 3'd2,
        ERR_BAD_ALLOC = 3'd3,
        ERR_OOM       = 3'd4
    } t_err;

    // input beat
    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] start_address;
        logic [63:0] byte_count;
        logic        no_map_flag;
    } t_item;

    // result beat
    typedef struct packed {
        logic [2:0]  error_code;
        logic        overlap_hit;
        logic [63:0] block_address;
    } t_result;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SET_ERR,
        OP_REM_START,
        OP_APPLY_SIZE,
        OP_APPLY_HI,
        OP_APPLY_LO,
        OP_SCAN_INIT,
        OP_SCAN_RD,
        OP_SCAN_CK,
        OP_ALLOC_PREP,
        OP_ALLOC_COMMIT,
        OP_COPY_INIT,
        OP_COPY_RD,
        OP_COPY_WR,
        OP_FINAL_WR
    } t_op;

    // table walk flavors
    typedef enum logic [1:0] {
        SCAN_INSERT,
        SCAN_QUERY,
        SCAN_WALK
    } t_scan;

    // remainder unit operand select
    typedef enum logic [1:0] {
        REM_COUNT,
        REM_SUM,
        REM_LO
    } t_rsel;

    // controller to datapath
    typedef struct packed {
        t_op   op;
        logic  tsel;
        t_scan mode;
        t_rsel rsel;
        t_err  err;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] action;
        logic       flag;
        logic       len_zero;
        logic       res_bad;
        logic       alloc_bad;
        logic       rem_busy;
        logic       scan_done;
        logic       oom;
        logic       full;
        logic       copy_done;
    } t_stat;

endpackage

// File: rtl/page_range_reserve_allocator_core.sv
// ----------------------------------------------------------------------------
// page_range_reserve_allocator_core
// sorted reserved / no-map page range tables with query and bump allocation
// ----------------------------------------------------------------------------
// channel   direction  handshake
// item      in         start high while busy low accepts the beat
// result    out        o_result_strobe high for one cycle, no back-pressure
// config    in         i_cfg_we writes i_cfg_data to register i_cfg_index
//
// one item at a time; busy stays high from acceptance until the result beat.
// query: a read and a check per table entry visited.
// reserve: two remainder passes, then a walk and a shift of each touched table.
// alloc adds a third remainder pass and a walk of the reserved table.
// the one-read-port table rams and the multi-cycle remainder unit set the run time.
// reset is synchronous and leaves both tables empty with no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "page_range_reserve_allocator_core_macros.svh"

module page_range_reserve_allocator_core #(
    parameter int TABLE_DEPTH = prra_pkg::DEF_TABLE_DEPTH,
    parameter int PAGE_BYTES  = prra_pkg::DEF_PAGE_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_data,
    input  logic              start,
    output logic              busy,
    input  prra_pkg::t_item   i_item,
    output logic              o_result_strobe,
    output prra_pkg::t_result o_result
);

    prra_pkg::t_cmd  cmd;
    prra_pkg::t_stat stat;

    // sequencer
    prra_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_strobe (o_result_strobe)
    );

    // tables and arithmetic
    prra_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PAGE_BYTES  (PAGE_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_result    (o_result)
    );

    // checks
    `PRRA_ASSERT_NR(a_reset_idle, i_clk, !i_rst_n |=> !busy, "not idle after reset")
    `PRRA_ASSERT_CLK(a_accept_busy, i_clk, i_rst_n, start && !busy |=> busy,
        "accepted beat did not raise busy")
    `PRRA_ASSERT_CLK(a_strobe_idle, i_clk, i_rst_n, o_result_strobe |=> !busy,
        "result beat not followed by idle")
    `PRRA_ASSERT_CLK(a_err_range, i_clk, i_rst_n,
        o_result_strobe |-> o_result.error_code <= 3'd4, "error code out of range")

endmodule

// File: rtl/prra_ram.sv
// ----------------------------------------------------------------------------
// prra_ram
// generic one write, one read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prra_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/prra_rem.sv
// ----------------------------------------------------------------------------
// prra_rem
// remainder of a 64-bit value by the page size, computed step by step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prra_rem #(
    parameter int PAGE_BYTES = prra_pkg::DEF_PAGE_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [63:0]                   i_value,
    output logic                          o_busy,
    output logic [$clog2(PAGE_BYTES)-1:0] o_rem
);

    // eight byte folds, then eleven compare and subtract steps
    localparam int RW = $clog2(PAGE_BYTES);
    localparam int NB = 8;
    localparam int NR = 11;
    localparam logic [4:0]  STEPS = 5'(NB + NR);
    localparam logic [4:0]  RED_C = 5'(NR);
    localparam logic [31:0] DIV0  = 32'(PAGE_BYTES) << (NR - 1);

    // weight of byte k: 2^(8k) modulo the page size
    function automatic logic [255:0] weights();
        logic [255:0] tab;
        logic [63:0]  w;
        tab = '0;
        w   = 64'd1 % 64'(PAGE_BYTES);
        for (int k = 0; k < NB; k++) begin
            tab[k*32 +: 32] = w[31:0];
            w = (w * 64'd256) % 64'(PAGE_BYTES);
        end
        return tab;
    endfunction

    localparam logic [255:0] WTAB = weights();

    logic [63:0] r_val;
    logic [31:0] r_acc, r_div;
    logic [4:0]  r_cnt;
    logic [2:0]  k;
    logic [31:0] w_sel, prod;
    logic        acc_phase;

    // byte fold: next byte times its weight
    assign acc_phase = (r_cnt > RED_C);
    assign k         = 3'(STEPS - r_cnt);
    assign w_sel     = WTAB[{k, 5'd0} +: 32];
    assign prod      = {24'd0, r_val[7:0]} * w_sel;

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= STEPS;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 5'd1;
        end
    end

    // fold bytes into the accumulator, then reduce it below the page size
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
            r_acc <= '0;
            r_div <= DIV0;
        end else if (acc_phase) begin
            r_val <= {8'd0, r_val[63:8]};
            r_acc <= r_acc + prod;
        end else if (r_cnt != '0) begin
            if (r_acc >= r_div) begin
                r_acc <= r_acc - r_div;
            end
            r_div <= {1'b0, r_div[31:1]};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_rem  = r_acc[RW-1:0];

endmodule

// File: rtl/prra_dp.sv
// ----------------------------------------------------------------------------
// prra_dp
// datapath: item and config registers, range tables, table walk and copy logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prra_dp #(
    parameter int TABLE_DEPTH = prra_pkg::DEF_TABLE_DEPTH,
    parameter int PAGE_BYTES  = prra_pkg::DEF_PAGE_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_data,
    input  prra_pkg::t_item   i_item,
    input  prra_pkg::t_cmd    i_cmd,
    output prra_pkg::t_stat   o_stat,
    output prra_pkg::t_result o_result
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int RW = $clog2(PAGE_BYTES);
    localparam logic [CW-1:0] DEPTH_C  = CW'(TABLE_DEPTH);
    localparam logic [63:0]   PAGE_C   = 64'(PAGE_BYTES);
    localparam logic [63:0]   RSV_TOP  = ~(PAGE_C - 64'd1);
    localparam logic [63:0]   SIZE_TOP = ~PAGE_C + 64'd1;

    // config state
    logic [63:0] r_cursor, r_limit;
    logic        r_sealed;

    // item registers
    logic [1:0]  r_action;
    logic        r_flag;
    logic [63:0] r_lo, r_len, r_hi, r_cur;
    logic [2:0]  r_err;
    logic        r_hit;
    logic [63:0] r_block;

    // per table state and walk results
    logic [CW-1:0] r_used [2];
    logic [CW-1:0] r_ti   [2];
    logic [CW-1:0] r_tj   [2];
    logic [63:0]   r_tlo  [2];
    logic [63:0]   r_thi  [2];

    // walk and copy registers
    logic [CW-1:0] r_idx, r_src, r_dst;
    logic          r_found, r_up;
    logic [63:0]   r_acc_lo, r_acc_hi;

    // remainder unit
    logic          rem_start, rem_busy;
    logic [63:0]   rem_value;
    logic [RW-1:0] rem;
    logic [63:0]   rem_gap;

    // ram ports
    logic [127:0]  rd0, rd1, rdata, wdata;
    logic [AW-1:0] raddr, waddr;
    logic          we;
    logic [63:0]   ent_s, ent_e;

    // shared arithmetic and walk decisions
    logic [64:0]   sum;
    logic          t;
    logic          in_rng, skip, merge, q_hit, w_fit, scan_done;

    assign t       = i_cmd.tsel;
    assign sum     = {1'b0, r_lo} + {1'b0, r_len};
    assign rdata   = t ? rd1 : rd0;
    assign ent_s   = rdata[127:64];
    assign ent_e   = rdata[63:0];
    assign in_rng  = (r_idx < r_used[t]);
    assign rem_gap = PAGE_C - 64'(rem);

    // per entry decisions of the three walks
    always_comb begin
        skip  = 1'b0;
        merge = 1'b0;
        q_hit = 1'b0;
        w_fit = 1'b0;
        scan_done = 1'b0;
        unique case (i_cmd.mode)
            prra_pkg::SCAN_INSERT: begin
                skip  = !r_found && in_rng && (ent_e < r_lo);
                merge = !skip && in_rng && (ent_s <= r_acc_hi);
                scan_done = !skip && !merge;
            end
            prra_pkg::SCAN_QUERY: begin
                q_hit = in_rng && (r_lo < ent_e) && (sum[64] || (ent_s < sum[63:0]));
                scan_done = !in_rng || q_hit;
            end
            prra_pkg::SCAN_WALK: begin
                skip  = in_rng && (r_cur >= ent_e);
                w_fit = in_rng && !skip && (r_cur <= ent_s) && (r_len <= ent_s - r_cur);
                scan_done = !in_rng || w_fit;
            end
            default: begin
                scan_done = 1'b1;
            end
        endcase
    end

    // remainder operand
    always_comb begin
        unique case (i_cmd.rsel)
            prra_pkg::REM_COUNT: rem_value = r_len;
            prra_pkg::REM_SUM:   rem_value = sum[63:0];
            prra_pkg::REM_LO:    rem_value = r_lo;
            default:             rem_value = r_lo;
        endcase
    end
    assign rem_start = (i_cmd.op == prra_pkg::OP_REM_START);

    prra_rem #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rem_start),
        .i_value (rem_value),
        .o_busy  (rem_busy),
        .o_rem   (rem)
    );

    // ram address and write data
    always_comb begin
        raddr = (i_cmd.op == prra_pkg::OP_COPY_RD) ? r_src[AW-1:0] : r_idx[AW-1:0];
        we    = 1'b0;
        waddr = r_dst[AW-1:0];
        wdata = rdata;
        if (i_cmd.op == prra_pkg::OP_COPY_WR) begin
            we = 1'b1;
        end else if (i_cmd.op == prra_pkg::OP_FINAL_WR) begin
            we    = 1'b1;
            waddr = r_ti[t][AW-1:0];
            wdata = {r_tlo[t], r_thi[t]};
        end
    end

    prra_ram #(
        .WIDTH(128),
        .DEPTH(TABLE_DEPTH)
    ) u_ram_rsv (
        .i_clk   (i_clk),
        .i_we    (we && !t),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd0)
    );

    prra_ram #(
        .WIDTH(128),
        .DEPTH(TABLE_DEPTH)
    ) u_ram_nm (
        .i_clk   (i_clk),
        .i_we    (we && t),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd1)
    );

    // config registers, cursor and fill counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor  <= '0;
            r_limit   <= '0;
            r_sealed  <= 1'b0;
            r_used[0] <= '0;
            r_used[1] <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    prra_pkg::CFG_ALLOC_START: r_cursor <= i_cfg_data;
                    prra_pkg::CFG_ALLOC_LIMIT: r_limit  <= i_cfg_data;
                    prra_pkg::CFG_SEALED:      r_sealed <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.op == prra_pkg::OP_ALLOC_COMMIT) begin
                r_cursor <= r_cur + r_len;
            end
            if (i_cmd.op == prra_pkg::OP_FINAL_WR) begin
                if (r_up) begin
                    r_used[t] <= r_used[t] + CW'(1);
                end else begin
                    r_used[t] <= r_used[t] - r_tj[t] + r_ti[t] + CW'(1);
                end
            end
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            prra_pkg::OP_LOAD: begin
                r_action <= i_item.action;
                r_lo     <= i_item.start_address;
                r_len    <= i_item.byte_count;
                r_flag   <= i_item.no_map_flag;
                r_err    <= prra_pkg::ERR_OK;
                r_hit    <= 1'b0;
                r_block  <= '0;
            end
            prra_pkg::OP_SET_ERR: begin
                r_err <= i_cmd.err;
            end
            prra_pkg::OP_APPLY_SIZE: begin
                if (rem != '0) begin
                    r_len <= r_len + rem_gap;
                end
            end
            prra_pkg::OP_APPLY_HI: begin
                r_hi <= (rem != '0) ? sum[63:0] + rem_gap : sum[63:0];
            end
            prra_pkg::OP_APPLY_LO: begin
                r_lo <= r_lo - 64'(rem);
            end
            prra_pkg::OP_SCAN_INIT: begin
                r_idx    <= '0;
                r_found  <= 1'b0;
                r_acc_lo <= r_lo;
                r_acc_hi <= r_hi;
                if (i_cmd.mode == prra_pkg::SCAN_WALK) begin
                    r_cur <= r_cursor;
                end
            end
            prra_pkg::OP_SCAN_CK: begin
                unique case (i_cmd.mode)
                    prra_pkg::SCAN_INSERT: begin
                        if (!r_found && !skip) begin
                            r_found  <= 1'b1;
                            r_ti[t]  <= r_idx;
                        end
                        if (skip || merge) begin
                            r_idx <= r_idx + CW'(1);
                        end
                        if (merge) begin
                            if (ent_s < r_acc_lo) r_acc_lo <= ent_s;
                            if (ent_e > r_acc_hi) r_acc_hi <= ent_e;
                        end
                        if (scan_done) begin
                            r_tj[t]  <= r_idx;
                            r_tlo[t] <= r_acc_lo;
                            r_thi[t] <= r_acc_hi;
                        end
                    end
                    prra_pkg::SCAN_QUERY: begin
                        r_idx <= r_idx + CW'(1);
                        if (q_hit) r_hit <= 1'b1;
                    end
                    prra_pkg::SCAN_WALK: begin
                        if (!scan_done) begin
                            r_idx <= r_idx + CW'(1);
                            if (!skip) r_cur <= ent_e;
                        end
                    end
                    default: ;
                endcase
            end
            prra_pkg::OP_ALLOC_PREP: begin
                r_lo   <= r_cur;
                r_flag <= 1'b0;
            end
            prra_pkg::OP_ALLOC_COMMIT: begin
                r_block <= r_cur;
            end
            prra_pkg::OP_COPY_INIT: begin
                if (r_ti[t] == r_tj[t]) begin
                    r_up  <= 1'b1;
                    r_dst <= r_used[t];
                    r_src <= r_used[t] - CW'(1);
                end else begin
                    r_up  <= 1'b0;
                    r_dst <= r_ti[t] + CW'(1);
                    r_src <= r_tj[t];
                end
            end
            prra_pkg::OP_COPY_WR: begin
                if (r_up) begin
                    r_dst <= r_dst - CW'(1);
                    r_src <= r_src - CW'(1);
                end else begin
                    r_dst <= r_dst + CW'(1);
                    r_src <= r_src + CW'(1);
                end
            end
            default: ;
        endcase
    end

    // status to the controller
    always_comb begin
        o_stat.action    = r_action;
        o_stat.flag      = r_flag;
        o_stat.len_zero  = (r_len == '0);
        o_stat.res_bad   = r_sealed || sum[64] || (sum[63:0] > RSV_TOP);
        o_stat.alloc_bad = r_sealed || (r_len == '0) || (r_len > SIZE_TOP);
        o_stat.rem_busy  = rem_busy;
        o_stat.scan_done = scan_done;
        o_stat.oom       = (r_cur > r_limit) || (r_len > r_limit - r_cur);
        o_stat.full      = ((r_tj[0] == r_ti[0]) && (r_used[0] >= DEPTH_C)) ||
                           (r_flag && (r_tj[1] == r_ti[1]) && (r_used[1] >= DEPTH_C));
        o_stat.copy_done = r_up ? (r_dst <= r_ti[t]) : (r_src >= r_used[t]);
    end

    assign o_result.error_code    = r_err;
    assign o_result.overlap_hit   = r_hit;
    assign o_result.block_address = r_block;

endmodule

// File: rtl/prra_ctrl.sv
// ----------------------------------------------------------------------------
// prra_ctrl
// controller: sequences reserve, query and alloc items over the datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prra_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  prra_pkg::t_stat i_stat,
    output prra_pkg::t_cmd  o_cmd,
    output logic            o_busy,
    output logic            o_strobe
);

    typedef enum logic [22:0] {
        S_IDLE     = 23'd1 << 0,
        S_DISPATCH = 23'd1 << 1,
        S_REM_SZ   = 23'd1 << 2,
        S_W_INIT   = 23'd1 << 3,
        S_W_RD     = 23'd1 << 4,
        S_W_CK     = 23'd1 << 5,
        S_A_CHK    = 23'd1 << 6,
        S_RSV_CHK  = 23'd1 << 7,
        S_REM_HI   = 23'd1 << 8,
        S_LO_GO    = 23'd1 << 9,
        S_REM_LO   = 23'd1 << 10,
        S_I_INIT   = 23'd1 << 11,
        S_I_RD     = 23'd1 << 12,
        S_I_CK     = 23'd1 << 13,
        S_FULL_CHK = 23'd1 << 14,
        S_C_INIT   = 23'd1 << 15,
        S_C_RD     = 23'd1 << 16,
        S_C_WR     = 23'd1 << 17,
        S_C_FIN    = 23'd1 << 18,
        S_A_COMMIT = 23'd1 << 19,
        S_Q_RD     = 23'd1 << 20,
        S_Q_CK     = 23'd1 << 21,
        S_DONE     = 23'd1 << 22
    } t_state;

    t_state r_state, n_state;
    logic   r_tsel, n_tsel;

    // state and table select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tsel  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tsel  <= n_tsel;
        end
    end

    // next state and datapath command
    always_comb begin
        n_state    = r_state;
        n_tsel     = r_tsel;
        o_cmd.op   = prra_pkg::OP_NONE;
        o_cmd.tsel = r_tsel;
        o_cmd.mode = prra_pkg::SCAN_INSERT;
        o_cmd.rsel = prra_pkg::REM_SUM;
        o_cmd.err  = prra_pkg::ERR_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = prra_pkg::OP_LOAD;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.action)
                    prra_pkg::ACT_RESERVE: n_state = S_RSV_CHK;
                    prra_pkg::ACT_QUERY: begin
                        o_cmd.op   = prra_pkg::OP_SCAN_INIT;
                        o_cmd.mode = prra_pkg::SCAN_QUERY;
                        n_tsel     = i_stat.flag;
                        n_state    = S_Q_RD;
                    end
                    prra_pkg::ACT_ALLOC: begin
                        n_tsel = 1'b0;
                        if (i_stat.alloc_bad) begin
                            o_cmd.op  = prra_pkg::OP_SET_ERR;
                            o_cmd.err = prra_pkg::ERR_BAD_ALLOC;
                            n_state   = S_DONE;
                        end else begin
                            o_cmd.op   = prra_pkg::OP_REM_START;
                            o_cmd.rsel = prra_pkg::REM_COUNT;
                            n_state    = S_REM_SZ;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_REM_SZ: begin
                if (!i_stat.rem_busy) begin
                    o_cmd.op = prra_pkg::OP_APPLY_SIZE;
                    n_state  = S_W_INIT;
                end
            end
            S_W_INIT: begin
                o_cmd.op   = prra_pkg::OP_SCAN_INIT;
                o_cmd.mode = prra_pkg::SCAN_WALK;
                n_state    = S_W_RD;
            end
            S_W_RD: begin
                o_cmd.op = prra_pkg::OP_SCAN_RD;
                n_state  = S_W_CK;
            end
            S_W_CK: begin
                o_cmd.op   = prra_pkg::OP_SCAN_CK;
                o_cmd.mode = prra_pkg::SCAN_WALK;
                n_state    = i_stat.scan_done ? S_A_CHK : S_W_RD;
            end
            S_A_CHK: begin
                if (i_stat.oom) begin
                    o_cmd.op  = prra_pkg::OP_SET_ERR;
                    o_cmd.err = prra_pkg::ERR_OOM;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.op = prra_pkg::OP_ALLOC_PREP;
                    n_state  = S_RSV_CHK;
                end
            end
            S_RSV_CHK: begin
                priority if (i_stat.len_zero) begin
                    n_state = S_DONE;
                end else if (i_stat.res_bad) begin
                    o_cmd.op  = prra_pkg::OP_SET_ERR;
                    o_cmd.err = prra_pkg::ERR_BAD_RSV;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.op   = prra_pkg::OP_REM_START;
                    o_cmd.rsel = prra_pkg::REM_SUM;
                    n_state    = S_REM_HI;
                end
            end
            S_REM_HI: begin
                if (!i_stat.rem_busy) begin
                    o_cmd.op = prra_pkg::OP_APPLY_HI;
                    n_state  = S_LO_GO;
                end
            end
            S_LO_GO: begin
                o_cmd.op   = prra_pkg::OP_REM_START;
                o_cmd.rsel = prra_pkg::REM_LO;
                n_tsel     = 1'b0;
                n_state    = S_REM_LO;
            end
            S_REM_LO: begin
                if (!i_stat.rem_busy) begin
                    o_cmd.op = prra_pkg::OP_APPLY_LO;
                    n_state  = S_I_INIT;
                end
            end
            S_I_INIT: begin
                o_cmd.op = prra_pkg::OP_SCAN_INIT;
                n_state  = S_I_RD;
            end
            S_I_RD: begin
                o_cmd.op = prra_pkg::OP_SCAN_RD;
                n_state  = S_I_CK;
            end
            S_I_CK: begin
                o_cmd.op = prra_pkg::OP_SCAN_CK;
                if (i_stat.scan_done) begin
                    if (!r_tsel && i_stat.flag) begin
                        n_tsel  = 1'b1;
                        n_state = S_I_INIT;
                    end else begin
                        n_state = S_FULL_CHK;
                    end
                end else begin
                    n_state = S_I_RD;
                end
            end
            S_FULL_CHK: begin
                n_tsel = 1'b0;
                if (i_stat.full) begin
                    o_cmd.op  = prra_pkg::OP_SET_ERR;
                    o_cmd.err = prra_pkg::ERR_FULL;
                    n_state   = S_DONE;
                end else begin
                    n_state = S_C_INIT;
                end
            end
            S_C_INIT: begin
                o_cmd.op = prra_pkg::OP_COPY_INIT;
                n_state  = S_C_RD;
            end
            S_C_RD: begin
                if (i_stat.copy_done) begin
                    n_state = S_C_FIN;
                end else begin
                    o_cmd.op = prra_pkg::OP_COPY_RD;
                    n_state  = S_C_WR;
                end
            end
            S_C_WR: begin
                o_cmd.op = prra_pkg::OP_COPY_WR;
                n_state  = S_C_RD;
            end
            S_C_FIN: begin
                o_cmd.op = prra_pkg::OP_FINAL_WR;
                if (!r_tsel && i_stat.flag) begin
                    n_tsel  = 1'b1;
                    n_state = S_C_INIT;
                end else if (i_stat.action == prra_pkg::ACT_ALLOC) begin
                    n_state = S_A_COMMIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_A_COMMIT: begin
                o_cmd.op = prra_pkg::OP_ALLOC_COMMIT;
                n_state  = S_DONE;
            end
            S_Q_RD: begin
                o_cmd.op = prra_pkg::OP_SCAN_RD;
                n_state  = S_Q_CK;
            end
            S_Q_CK: begin
                o_cmd.op   = prra_pkg::OP_SCAN_CK;
                o_cmd.mode = prra_pkg::SCAN_QUERY;
                n_state    = i_stat.scan_done ? S_DONE : S_Q_RD;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_DONE);

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// page range reserve allocator testbench
// drives reserve, query and alloc commands under several register settings,
// predicts every result with a behavioral copy of both range tables and
// checks each result beat field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int DEPTH = prra_pkg::DEF_TABLE_DEPTH;
    localparam logic [63:0] PAGE = 64'(prra_pkg::DEF_PAGE_BYTES);
    localparam logic [63:0] MAXV = 64'hFFFF_FFFF_FFFF_FFFF;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [63:0]       cfg_data;
    logic              cmd_start;
    logic              busy;
    prra_pkg::t_item   item;
    logic              res_strobe;
    prra_pkg::t_result res;

    page_range_reserve_allocator_core DUT (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data), .start(cmd_start), .busy(busy), .i_item(item),
        .o_result_strobe(res_strobe), .o_result(res)
    );

    // predictor state: two range tables plus registers
    logic [63:0] rsv_lo [DEPTH];
    logic [63:0] rsv_hi [DEPTH];
    int          rsv_cnt;
    logic [63:0] nm_lo  [DEPTH];
    logic [63:0] nm_hi  [DEPTH];
    int          nm_cnt;
    logic [63:0] cursor, lim_reg;
    logic        sealed_reg;

    prra_pkg::t_item   pending_items [$];
    prra_pkg::t_result expected_results [$];
    int      errors = 0;
    int      n_results = 0;
    int      n_alloc_ok = 0;
    int      n_full = 0;
    bit      quiet_drive = 0;

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        #400ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [63:0] page_up(logic [63:0] x);
        logic [63:0] r;
        r = x % PAGE;
        return (r != 0) ? x + (PAGE - r) : x;
    endfunction

    function automatic int touch_idx(bit nm, logic [63:0] lo);
        int i;
        i = 0;
        if (nm) while (i < nm_cnt && nm_hi[i] < lo) i++;
        else    while (i < rsv_cnt && rsv_hi[i] < lo) i++;
        return i;
    endfunction

    function automatic bit has_room(bit nm, logic [63:0] lo, logic [63:0] hi);
        int i;
        i = touch_idx(nm, lo);
        if (nm) return (i < nm_cnt && nm_lo[i] <= hi) || nm_cnt < DEPTH;
        return (i < rsv_cnt && rsv_lo[i] <= hi) || rsv_cnt < DEPTH;
    endfunction

    // merge one page range into a table, keeping it sorted and disjoint
    task automatic merge_range(bit nm, logic [63:0] lo, logic [63:0] hi);
        logic [63:0] s [DEPTH];
        logic [63:0] e [DEPTH];
        int n, i, j, gone;
        n = nm ? nm_cnt : rsv_cnt;
        for (int k = 0; k < n; k++) begin
            s[k] = nm ? nm_lo[k] : rsv_lo[k];
            e[k] = nm ? nm_hi[k] : rsv_hi[k];
        end
        i = touch_idx(nm, lo);
        j = i;
        while (j < n && s[j] <= hi) begin
            if (s[j] < lo) lo = s[j];
            if (e[j] > hi) hi = e[j];
            j++;
        end
        if (j == i) begin
            for (int k = n; k > i; k--) begin
                s[k] = s[k-1];
                e[k] = e[k-1];
            end
            n++;
        end else begin
            gone = j - i - 1;
            for (int k = i + 1; k + gone < n; k++) begin
                s[k] = s[k+gone];
                e[k] = e[k+gone];
            end
            n -= gone;
        end
        s[i] = lo;
        e[i] = hi;
        for (int k = 0; k < n; k++) begin
            if (nm) begin nm_lo[k] = s[k]; nm_hi[k] = e[k]; end
            else begin rsv_lo[k] = s[k]; rsv_hi[k] = e[k]; end
        end
        if (nm) nm_cnt = n; else rsv_cnt = n;
    endtask

    task automatic reserve_pages(logic [63:0] lo, logic [63:0] len, bit nm,
                                 output prra_pkg::t_err code);
        logic [63:0] hi;
        code = prra_pkg::ERR_OK;
        if (len == 0) return;
        if (sealed_reg || lo > MAXV - len || lo + len > MAXV - (PAGE - 1)) begin
            code = prra_pkg::ERR_BAD_RSV;
            return;
        end
        hi = page_up(lo + len);
        lo = lo - (lo % PAGE);
        if (!has_room(0, lo, hi) || (nm && !has_room(1, lo, hi))) begin
            code = prra_pkg::ERR_FULL;
            return;
        end
        merge_range(0, lo, hi);
        if (nm) merge_range(1, lo, hi);
    endtask

    function automatic bit span_overlaps(bit nm, logic [63:0] lo, logic [63:0] len);
        bit top;
        logic [63:0] hi;
        int n;
        top = len > MAXV - lo;
        hi = lo + len;
        n = nm ? nm_cnt : rsv_cnt;
        for (int i = 0; i < n; i++) begin
            if (nm) begin
                if (lo < nm_hi[i] && (top || nm_lo[i] < hi)) return 1;
            end else if (lo < rsv_hi[i] && (top || rsv_lo[i] < hi)) return 1;
        end
        return 0;
    endfunction

    // work out the result of one accepted command and update the tables
    task automatic predict_result(prra_pkg::t_item it);
        prra_pkg::t_result r;
        prra_pkg::t_err code;
        logic [63:0] size, cur;
        r = '0;
        code = prra_pkg::ERR_OK;
        case (it.action)
            prra_pkg::ACT_RESERVE: reserve_pages(it.start_address, it.byte_count,
                                                 it.no_map_flag, code);
            prra_pkg::ACT_QUERY: r.overlap_hit = span_overlaps(it.no_map_flag,
                                                               it.start_address,
                                                               it.byte_count);
            prra_pkg::ACT_ALLOC: begin
                if (sealed_reg || it.byte_count == 0 || it.byte_count > MAXV - PAGE + 1) begin
                    code = prra_pkg::ERR_BAD_ALLOC;
                end else begin
                    size = page_up(it.byte_count);
                    cur = cursor;
                    for (int i = 0; i < rsv_cnt; i++) begin
                        if (cur >= rsv_hi[i]) continue;
                        if (cur <= rsv_lo[i] && size <= rsv_lo[i] - cur) break;
                        cur = rsv_hi[i];
                    end
                    if (cur > lim_reg || size > lim_reg - cur) begin
                        code = prra_pkg::ERR_OOM;
                    end else begin
                        reserve_pages(cur, size, 0, code);
                        if (code == prra_pkg::ERR_OK) begin
                            r.block_address = cur;
                            cursor = cur + size;
                            n_alloc_ok++;
                        end
                    end
                end
            end
            default: ;
        endcase
        if (code == prra_pkg::ERR_FULL) n_full++;
        r.error_code = code;
        expected_results.push_back(r);
    endtask

    // driver: one command beat at a time, random gaps outside the quiet stretch
    always @(posedge clk) begin
        if (!rst_n) begin
            cmd_start <= 1'b0;
        end else if (cmd_start && !busy) begin
            predict_result(item);
            if (pending_items.size() > 0 && (quiet_drive || $urandom_range(99) >= 20)) begin
                item <= pending_items.pop_front();
            end else begin
                cmd_start <= 1'b0;
            end
        end else if (!cmd_start && pending_items.size() > 0
                     && (quiet_drive || $urandom_range(99) >= 20)) begin
            item      <= pending_items.pop_front();
            cmd_start <= 1'b1;
        end
    end

    // monitor: compare each result beat with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && res_strobe) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result beat");
                errors++;
            end else begin
                prra_pkg::t_result x;
                x = expected_results.pop_front();
                n_results++;
                if (res.error_code !== x.error_code) begin
                    $error("error_code exp %0d got %0d", x.error_code, res.error_code);
                    errors++;
                end
                if (res.overlap_hit !== x.overlap_hit) begin
                    $error("overlap_hit exp %0d got %0d", x.overlap_hit, res.overlap_hit);
                    errors++;
                end
                if (res.block_address !== x.block_address) begin
                    $error("block_address exp %h got %h", x.block_address, res.block_address);
                    errors++;
                end
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic prra_pkg::t_item mk(logic [1:0] a, logic [63:0] s, logic [63:0] c,
                                           logic f);
        prra_pkg::t_item it;
        it.action = a;
        it.start_address = s;
        it.byte_count = c;
        it.no_map_flag = f;
        return it;
    endfunction

    // mostly small spans in a narrow window so ranges merge and the tables fill
    function automatic prra_pkg::t_item rand_item(logic [63:0] base);
        int sel;
        logic [63:0] s, c;
        sel = $urandom_range(99);
        s = base + 64'($urandom_range(400)) * PAGE + 64'($urandom_range(PAGE - 1));
        c = 64'($urandom_range(3 * PAGE));
        if (sel < 5) s = rand64();
        if (sel >= 5 && sel < 10) c = rand64();
        if (sel < 40) return mk(prra_pkg::ACT_RESERVE, s, c, $urandom_range(1));
        if (sel < 70) return mk(prra_pkg::ACT_QUERY, s, c, $urandom_range(1));
        if (sel < 97) return mk(prra_pkg::ACT_ALLOC, s, c, $urandom_range(1));
        return mk(2'd3, s, c, $urandom_range(1));
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == prra_pkg::CFG_ALLOC_START) begin
            cursor = val;
        end else if (idx == prra_pkg::CFG_ALLOC_LIMIT) begin
            lim_reg = val;
        end else if (idx == prra_pkg::CFG_SEALED) begin
            sealed_reg = val[0];
        end
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || cmd_start || expected_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial begin
        logic [63:0] base;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        cmd_start = 0;
        item = '0;
        rsv_cnt = 0;
        nm_cnt = 0;
        cursor = 0;
        lim_reg = 0;
        sealed_reg = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty tables, limit zero, edges of every field
        pending_items.push_back(mk(prra_pkg::ACT_ALLOC, 0, 1, 0));
        pending_items.push_back(mk(prra_pkg::ACT_QUERY, 0, MAXV, 0));
        pending_items.push_back(mk(prra_pkg::ACT_RESERVE, 64'h1234, 0, 1));
        pending_items.push_back(mk(prra_pkg::ACT_RESERVE, MAXV, 1, 0));
        pending_items.push_back(mk(prra_pkg::ACT_RESERVE, MAXV - PAGE, 2, 0));
        pending_items.push_back(mk(prra_pkg::ACT_RESERVE, MAXV - 2 * PAGE, PAGE, 1));
        pending_items.push_back(mk(prra_pkg::ACT_RESERVE, 64'h1001, 64'h10, 1));
        pending_items.push_back(mk(prra_pkg::ACT_RESERVE, 64'h3000, 64'h1000, 0));
        pending_items.push_back(mk(prra_pkg::ACT_RESERVE, 64'h2000, 64'h1000, 0));
        pending_items.push_back(mk(prra_pkg::ACT_QUERY, 64'h1fff, 1, 1));
        pending_items.push_back(mk(prra_pkg::ACT_QUERY, 64'h2000, 1, 1));
        pending_items.push_back(mk(prra_pkg::ACT_QUERY, MAXV, MAXV, 0));
        pending_items.push_back(mk(2'd3, MAXV, MAXV, 1));
        drain();
        write_reg(prra_pkg::CFG_ALLOC_LIMIT, 64'h10_0000);
        write_reg(prra_pkg::CFG_ALLOC_START, 0);
        pending_items.push_back(mk(prra_pkg::ACT_ALLOC, 0, 0, 0));
        pending_items.push_back(mk(prra_pkg::ACT_ALLOC, 0, MAXV, 0));
        pending_items.push_back(mk(prra_pkg::ACT_ALLOC, 0, MAXV - PAGE + 1, 0));
        pending_items.push_back(mk(prra_pkg::ACT_ALLOC, 0, MAXV - PAGE + 2, 0));
        pending_items.push_back(mk(prra_pkg::ACT_ALLOC, 0, 64'h1000, 0));
        pending_items.push_back(mk(prra_pkg::ACT_ALLOC, 0, 64'h1001, 0));
        pending_items.push_back(mk(prra_pkg::ACT_ALLOC, 0, 64'h20_0000, 0));
        drain();
        write_reg(prra_pkg::CFG_SEALED, 1);
        pending_items.push_back(mk(prra_pkg::ACT_RESERVE, 64'h9000, 5, 0));
        pending_items.push_back(mk(prra_pkg::ACT_ALLOC, 0, 5, 0));
        pending_items.push_back(mk(prra_pkg::ACT_QUERY, 64'h9000, 5, 0));
        drain();
        write_reg(prra_pkg::CFG_SEALED, 0);
        write_reg(prra_pkg::CFG_ALLOC_LIMIT, MAXV);
        write_reg(prra_pkg::CFG_ALLOC_START, MAXV - 4 * PAGE);
        pending_items.push_back(mk(prra_pkg::ACT_ALLOC, 0, PAGE, 0));
        pending_items.push_back(mk(prra_pkg::ACT_ALLOC, 0, 8 * PAGE, 0));
        drain();

        // random phases with different windows and register settings
        for (int ph = 0; ph < 7; ph++) begin
            base = (ph % 2) ? 64'(ph) << 40 : 64'(ph) * 64'h10_0000;
            write_reg(prra_pkg::CFG_ALLOC_START, base + 64'($urandom_range(200)) * PAGE);
            write_reg(prra_pkg::CFG_ALLOC_LIMIT,
                      (ph == 6) ? MAXV : base + 64'($urandom_range(600)) * PAGE);
            quiet_drive = (ph == 3);
            for (int n = 0; n < 250; n++) pending_items.push_back(rand_item(base));
            drain();
        end

        $display("covered %0d result beats, %0d good allocations, %0d table-full answers",
                 n_results, n_alloc_ok, n_full);
        $display("final table sizes: reserved %0d, no-map %0d", rsv_cnt, nm_cnt);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
